@@ rtl/bbl_pkg.sv @@
`timescale 1ns / 1ps

package bbl_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int LINE_W  = 2 * PIX_W;
  localparam int DIM_W   = 12;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COORD_W = 11;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int WIN_N   = 3;
  localparam int NUM_OUT = 4;

  localparam int IN_DATA_W  = ((PIX_W + 7) / 8) * 8;
  localparam int OUT_BITS   = PIX_W + 2 * COORD_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int RECIP_1 = 1 << RECIP_SHIFT;
  localparam int RECIP_2 = ((1 << RECIP_SHIFT) + 1) / 2;
  localparam int RECIP_3 = ((1 << RECIP_SHIFT) + 2) / 3;
  localparam int RECIP_4 = ((1 << RECIP_SHIFT) + 3) / 4;
  localparam int RECIP_6 = ((1 << RECIP_SHIFT) + 5) / 6;
  localparam int RECIP_9 = ((1 << RECIP_SHIFT) + 8) / 9;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // index [row], top row first
  typedef pix_t [WIN_N-1:0] win_col_t;
  // index [column], oldest column first
  typedef win_col_t [WIN_N-1:0] win_t;

  // mask bits: up-left, up, left, here (relative to the newest pixel)
  typedef struct packed {
    win_t               win;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [NUM_OUT-1:0] mask;
  } job_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd2:    r = RECIP_W'(RECIP_2);
      4'd3:    r = RECIP_W'(RECIP_3);
      4'd4:    r = RECIP_W'(RECIP_4);
      4'd6:    r = RECIP_W'(RECIP_6);
      4'd9:    r = RECIP_W'(RECIP_9);
      default: r = RECIP_W'(RECIP_1);
    endcase
    return r;
  endfunction

endpackage

@@ rtl/bbl_ram.sv @@
`timescale 1ns / 1ps

module bbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bbl_front.sv @@
`timescale 1ns / 1ps

module bbl_front import bbl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  pix_t                 s_pix,
  input  logic                 q_full,
  output logic                 q_push,
  output job_t                 q_job
);

  logic [DIM_W-1:0]   img_w;
  logic [DIM_W-1:0]   img_h;
  logic [COL_W-1:0]   col_cnt;
  logic [ROW_W-1:0]   row_cnt;

  logic               b_valid;
  pix_t               b_pix;
  logic [COL_W-1:0]   b_col;
  logic [ROW_W-1:0]   b_row;
  logic [NUM_OUT-1:0] b_mask;
  logic               fwd_hit;
  logic [LINE_W-1:0]  fwd_data;
  win_t               win;

  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic               wrap_col;
  logic [DIM_W-1:0]   r_tmp;
  logic [COL_W-1:0]   c_cur;
  logic [ROW_W-1:0]   r_cur;
  logic [DIM_W-1:0]   c_inc;
  logic [DIM_W-1:0]   r_inc;
  logic [COL_W-1:0]   col_cnt_next;
  logic [ROW_W-1:0]   row_cnt_next;
  logic [NUM_OUT-1:0] mask_next;
  logic               prev_row;
  logic               last_row;
  logic               prev_col;
  logic               last_col;

  logic               acc;
  logic               b_move;
  logic [LINE_W-1:0]  ram_rdata;
  logic [LINE_W-1:0]  line_rd;
  pix_t               above;
  pix_t               above2;
  win_t               win_next;

  always_comb begin
    if (img_w == '0) begin
      w_eff = DIM_W'(1);
    end else if (img_w > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = img_w;
    end
    if (img_h == '0) begin
      h_eff = DIM_W'(1);
    end else if (img_h > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_h;
    end

    wrap_col = DIM_W'(col_cnt) >= w_eff;
    c_cur    = wrap_col ? '0 : col_cnt;
    r_tmp    = DIM_W'(row_cnt) + DIM_W'(wrap_col);
    r_cur    = (r_tmp >= h_eff) ? '0 : r_tmp[ROW_W-1:0];

    c_inc = DIM_W'(c_cur) + DIM_W'(1);
    r_inc = DIM_W'(r_cur) + DIM_W'(1);
    if (c_inc >= w_eff) begin
      col_cnt_next = '0;
      row_cnt_next = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_cnt_next = c_inc[COL_W-1:0];
      row_cnt_next = r_cur;
    end

    prev_row     = r_cur != '0;
    last_row     = r_inc == h_eff;
    prev_col     = c_cur != '0;
    last_col     = c_inc == w_eff;
    mask_next[0] = prev_row && prev_col;
    mask_next[1] = prev_row && last_col;
    mask_next[2] = last_row && prev_col;
    mask_next[3] = last_row && last_col;
  end

  assign b_move  = b_valid && ((b_mask == '0) || !q_full);
  assign s_ready = !b_valid || b_move;
  assign acc     = s_valid && s_ready;

  assign line_rd = fwd_hit ? fwd_data : ram_rdata;
  assign above   = pix_t'(line_rd[PIX_W-1:0]);
  assign above2  = pix_t'(line_rd[LINE_W-1:PIX_W]);

  always_comb begin
    win_next       = win;
    win_next[0]    = win[1];
    win_next[1]    = win[2];
    win_next[2][0] = above2;
    win_next[2][1] = above;
    win_next[2][2] = b_pix;
  end

  assign q_push     = b_move && (b_mask != '0);
  assign q_job.win  = win_next;
  assign q_job.col  = b_col;
  assign q_job.row  = b_row;
  assign q_job.mask = b_mask;

  bbl_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (b_move),
    .waddr (b_col),
    .wdata ({above, b_pix}),
    .re    (acc),
    .raddr (c_cur),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w   <= DIM_W'(RESET_WIDTH);
      img_h   <= DIM_W'(RESET_HEIGHT);
      col_cnt <= '0;
      row_cnt <= '0;
      b_valid <= 1'b0;
      fwd_hit <= 1'b0;
      win     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH:  img_w <= cfg_data;
          REG_IMAGE_HEIGHT: img_h <= cfg_data;
          default: ;
        endcase
      end
      if (acc) begin
        col_cnt <= col_cnt_next;
        row_cnt <= row_cnt_next;
        // forward the line word written at the same edge as this read
        fwd_hit <= b_move && (b_col == c_cur);
      end
      if (b_move) begin
        win <= win_next;
      end
      if (acc) begin
        b_valid <= 1'b1;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_pix    <= s_pix;
      b_col    <= c_cur;
      b_row    <= r_cur;
      b_mask   <= mask_next;
      fwd_data <= {above, b_pix};
    end
  end

endmodule

@@ rtl/bbl_queue.sv @@
`timescale 1ns / 1ps

module bbl_queue import bbl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head_job
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign valid    = count != '0;
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ rtl/bbl_back.sv @@
`timescale 1ns / 1ps

module bbl_back import bbl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  job_t                  q_job,
  output logic                  q_pop,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic [OUT_DATA_W-1:0] m_data,
  output logic                  m_last
);

  logic               head_loaded;
  logic [NUM_OUT-1:0] pend;

  logic               v1;
  logic [SUM_W-1:0]   s1_red;
  logic [SUM_W-1:0]   s1_green;
  logic [SUM_W-1:0]   s1_blue;
  logic [RECIP_W-1:0] s1_recip;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic               s1_last;

  logic               v2;
  logic [PROD_W-1:0]  s2_red;
  logic [PROD_W-1:0]  s2_green;
  logic [PROD_W-1:0]  s2_blue;
  logic [COORD_W-1:0] s2_x;
  logic [COORD_W-1:0] s2_y;
  logic               s2_last;

  logic               adv;
  logic               issue;
  logic [NUM_OUT-1:0] pend_cur;
  logic [NUM_OUT-1:0] sel;
  logic [NUM_OUT-1:0] remaining;
  logic               dx;
  logic               dy;
  logic [WIN_N-1:0]   col_ok;
  logic [WIN_N-1:0]   row_ok;
  logic [1:0]         n_col;
  logic [1:0]         n_row;
  logic [CNT_W-1:0]   cnt;
  logic [SUM_W-1:0]   sum_red;
  logic [SUM_W-1:0]   sum_green;
  logic [SUM_W-1:0]   sum_blue;
  logic [COL_W-1:0]   x;
  logic [ROW_W-1:0]   y;

  assign adv       = !m_valid || m_ready;
  assign pend_cur  = head_loaded ? pend : q_job.mask;
  assign sel       = pend_cur & (~pend_cur + NUM_OUT'(1));
  assign remaining = pend_cur & ~sel;
  assign issue     = q_valid && adv;
  assign q_pop     = issue && (remaining == '0);

  always_comb begin
    dx = sel[1] || sel[3];
    dy = sel[2] || sel[3];

    col_ok[0] = !dx && (q_job.col > COL_W'(1));
    col_ok[1] = q_job.col != '0;
    col_ok[2] = 1'b1;
    row_ok[0] = !dy && (q_job.row > ROW_W'(1));
    row_ok[1] = q_job.row != '0;
    row_ok[2] = 1'b1;

    n_col = 2'(col_ok[0]) + 2'(col_ok[1]) + 2'(col_ok[2]);
    n_row = 2'(row_ok[0]) + 2'(row_ok[1]) + 2'(row_ok[2]);
    cnt   = CNT_W'(n_col) * CNT_W'(n_row);

    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int j = 0; j < WIN_N; j++) begin
      for (int i = 0; i < WIN_N; i++) begin
        if (col_ok[j] && row_ok[i]) begin
          sum_red   = sum_red   + SUM_W'(q_job.win[j][i].red);
          sum_green = sum_green + SUM_W'(q_job.win[j][i].green);
          sum_blue  = sum_blue  + SUM_W'(q_job.win[j][i].blue);
        end
      end
    end

    x = dx ? q_job.col : q_job.col - COL_W'(1);
    y = dy ? q_job.row : q_job.row - ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_loaded <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      m_valid     <= 1'b0;
    end else begin
      if (issue) begin
        head_loaded <= remaining != '0;
      end
      if (adv) begin
        v1      <= issue;
        v2      <= v1;
        m_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend <= remaining;
    end
    if (adv) begin
      s1_red   <= sum_red;
      s1_green <= sum_green;
      s1_blue  <= sum_blue;
      s1_recip <= recip(cnt);
      s1_x     <= COORD_W'(x);
      s1_y     <= COORD_W'(y);
      s1_last  <= remaining == '0;

      s2_red   <= PROD_W'(s1_red) * PROD_W'(s1_recip);
      s2_green <= PROD_W'(s1_green) * PROD_W'(s1_recip);
      s2_blue  <= PROD_W'(s1_blue) * PROD_W'(s1_recip);
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_last  <= s1_last;

      m_data <= OUT_DATA_W'({s2_y, s2_x,
                             s2_blue[RECIP_SHIFT +: CH_W],
                             s2_green[RECIP_SHIFT +: CH_W],
                             s2_red[RECIP_SHIFT +: CH_W]});
      m_last <= s2_last;
    end
  end

endmodule

@@ rtl/rgb_box_blur_3x3_top.sv @@
`timescale 1ns / 1ps
// Channel   | Signals                                  | Transaction
// ----------+------------------------------------------+----------------------------------
// input     | s_tvalid, s_tready, s_tdata              | one RGB pixel, raster order
// output    | m_tvalid, m_tready, m_tdata, m_tlast     | one blurred pixel with coordinates
// config    | cfg_we, cfg_index, cfg_data              | one register write
//
// The front takes one pixel per cycle while the job queue is not full; its line store is one
// dual-port RAM, read at accept and written when the pixel leaves the front register. The back
// emits one result per cycle while m_tready allows; a pixel causing n results (up to 4 at the
// last row and column) holds it until all issue, absorbed by a 4-entry job queue. A result passes
// the front register, queue, s1, s2 and output registers. Reset (rst, synchronous) clears counters
// and window and loads 640 x 480, not line stores. Output stalls hold the whole back and the queue.

module rgb_box_blur_3x3_top import bbl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // red_out, green_out, blue_out, out_col, out_row, pad
  output logic                  m_tlast
);

  pix_t s_pix;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t push_job;
  job_t head_job;

  assign s_pix.red   = s_tdata[CH_W-1:0];
  assign s_pix.green = s_tdata[2*CH_W-1:CH_W];
  assign s_pix.blue  = s_tdata[3*CH_W-1:2*CH_W];

  bbl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_pix     (s_pix),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  bbl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_job (head_job)
  );

  bbl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_data  (m_tdata),
    .m_last  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("job queue read while empty");

  a_job_has_work: assert property (@(posedge clk) disable iff (rst)
    q_push |-> push_job.mask != '0)
    else $error("job without results queued");
`endif

endmodule
